[hw/rtl/bgi_pkg.sv]
// Package for the bilinear grid interpolator.
// Holds grid sizes, fixed-point widths, command and register codes, and shared types.
// No dependencies.
package bgi_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W      = 32;
    localparam int FIELD_IDX_W = 6;
    localparam int CNT_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CIDX_W      = $clog2(MAX_COLS);
    localparam int RIDX_W      = $clog2(MAX_ROWS);
    localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(GRID_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS     = 3'd0,
        CFG_ROWS     = 3'd1,
        CFG_X_ORIGIN = 3'd2,
        CFG_X_SCALE  = 3'd3,
        CFG_Y_ORIGIN = 3'd4,
        CFG_Y_SCALE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                     cmd;
        logic [FIELD_IDX_W-1:0]   row_index;
        logic [FIELD_IDX_W-1:0]   col_index;
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] query_x;
        logic signed [DATA_W-1:0] query_y;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]         cols;
        logic [CNT_W-1:0]         rows;
        logic signed [DATA_W-1:0] x_origin;
        logic [DATA_W-1:0]        x_scale;
        logic signed [DATA_W-1:0] y_origin;
        logic [DATA_W-1:0]        y_scale;
    } t_cfg;

endpackage

[hw/rtl/bgi_in_if.sv]
// Input channel of the bilinear grid interpolator: load and query words.
// Depends on bgi_pkg.
interface bgi_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [bgi_pkg::FIELD_IDX_W-1:0]  row_index;
    logic [bgi_pkg::FIELD_IDX_W-1:0]  col_index;
    logic signed [bgi_pkg::DATA_W-1:0] sample_value;
    logic signed [bgi_pkg::DATA_W-1:0] query_x;
    logic signed [bgi_pkg::DATA_W-1:0] query_y;

    modport source (output valid, cmd, row_index, col_index, sample_value, query_x, query_y,
                    input ready);
    modport sink (input valid, cmd, row_index, col_index, sample_value, query_x, query_y,
                  output ready);
endinterface

[hw/rtl/bgi_out_if.sv]
// Output channel of the bilinear grid interpolator: interpolated values.
// Depends on bgi_pkg.
interface bgi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bgi_pkg::DATA_W-1:0] interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink (input valid, interp_value, output ready);
endinterface

[hw/rtl/bgi_cfg_if.sv]
// Configuration write channel of the bilinear grid interpolator.
// Depends on bgi_pkg.
interface bgi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bgi_pkg::CFG_IDX_W-1:0]     index;
    logic [bgi_pkg::DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bilinear_grid_interpolator.sv]
// Bilinear grid interpolator: Q16.16 sample grid with load and query words.
// Channel i_in takes a word: cmd 0 writes sample_value at (row_index, col_index),
// cmd 1 asks for the bilinear value at (query_x, query_y); only queries answer.
// Channel o_out delivers one interp_value per query, in order of acceptance.
// Channel i_cfg writes the registers cols, rows, x_origin, x_scale, y_origin,
// y_scale by index; it is always ready. The user must use it only while the block
// is idle; the block itself does not enforce this. Throughput is one word per cycle
// while the output does not stall: a two-word queue feeds a nine-stage back end
// whose two 32x32 position multipliers and four copies of the grid store (one per
// corner, each written by every load) let a query start every cycle.
// When o_out.valid is high and o_out.ready is low the back end holds; the queue
// fills its two places, then i_in.ready falls. Reset clears the pipeline and queue
// and sets the registers to 64, 64, 0, 1.0, 0, 1.0. The grid is undefined after
// reset and each sample must be loaded before a query reads it.
// Depends on bgi_pkg, bgi_in_if, bgi_out_if, bgi_cfg_if, bgi_front, bgi_back.
module bilinear_grid_interpolator (
    input logic       i_clk,
    input logic       i_rst_n,
    bgi_cfg_if.sink   i_cfg,
    bgi_in_if.sink    i_in,
    bgi_out_if.source o_out
);
    import bgi_pkg::*;

    t_cfg  r_cfg;
    t_item w_in_item;
    t_item w_q_item;
    logic  w_q_valid;
    logic  w_q_pop;
    logic  w_back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols     <= CNT_W'(MAX_COLS);
            r_cfg.rows     <= CNT_W'(MAX_ROWS);
            r_cfg.x_origin <= '0;
            r_cfg.x_scale  <= DATA_W'(1 << FRAC_BITS);
            r_cfg.y_origin <= '0;
            r_cfg.y_scale  <= DATA_W'(1 << FRAC_BITS);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_COLS:     r_cfg.cols     <= i_cfg.data[CNT_W-1:0];
                CFG_ROWS:     r_cfg.rows     <= i_cfg.data[CNT_W-1:0];
                CFG_X_ORIGIN: r_cfg.x_origin <= i_cfg.data;
                CFG_X_SCALE:  r_cfg.x_scale  <= i_cfg.data;
                CFG_Y_ORIGIN: r_cfg.y_origin <= i_cfg.data;
                CFG_Y_SCALE:  r_cfg.y_scale  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_in_item.cmd          = t_cmd'(i_in.cmd);
        w_in_item.row_index    = i_in.row_index;
        w_in_item.col_index    = i_in.col_index;
        w_in_item.sample_value = i_in.sample_value;
        w_in_item.query_x      = i_in.query_x;
        w_in_item.query_y      = i_in.query_y;
    end

    assign w_q_pop = w_q_valid && w_back_ready;

    bgi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in.valid),
        .o_push_ready (i_in.ready),
        .i_item       (w_in_item),
        .o_valid      (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_q_pop)
    );

    bgi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_q_pop),
        .i_item      (w_q_item),
        .o_ready     (w_back_ready),
        .o_valid     (o_out.valid),
        .o_value     (o_out.interp_value),
        .i_out_ready (o_out.ready)
    );

`ifndef NO_ASSERTIONS
    a_back_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_ready == (!o_out.valid || o_out.ready))
        else $error("back end ready does not follow the output stall");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_back_ready |-> !w_q_pop)
        else $error("queue popped while the back end is stalled");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.interp_value)))
        else $error("result changed while the receiver stalled");
`endif
endmodule

[hw/rtl/bgi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/bgi_front.sv]
// Front end of the bilinear grid interpolator: a short queue of accepted words.
// Depends on bgi_pkg.
module bgi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bgi_pkg::t_item i_item,
    output logic           o_valid,
    output bgi_pkg::t_item o_item,
    input  logic           i_pop
);
    import bgi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_push_valid && o_push_ready;
    assign o_valid      = (r_count != '0);
    assign o_item       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(w_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end
endmodule

[hw/rtl/bgi_back.sv]
// Back end of the bilinear grid interpolator: position mapping, grid store and blending.
// Depends on bgi_pkg and bgi_ram.
module bgi_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bgi_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    input  bgi_pkg::t_item                   i_item,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic signed [bgi_pkg::DATA_W-1:0] o_value,
    input  logic                             i_out_ready
);
    import bgi_pkg::*;

    localparam int ONE    = 1 << FRAC_BITS;
    localparam int W_W    = FRAC_BITS + 1;
    localparam int PROD_W = DATA_W + W_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MUL_W  = 2 * DATA_W;
    localparam int SH_W   = MUL_W - FRAC_BITS;
    localparam int POS_W  = CIDX_W + FRAC_BITS;
    localparam int POSR_W = RIDX_W + FRAC_BITS;
    localparam int LIM_W  = CNT_W + FRAC_BITS;

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [RIDX_W-1:0] row,
                                                    input logic [CIDX_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_sum(
        input logic signed [PROD_W-1:0] a, input logic signed [PROD_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(ONE / 2);
        return s[FRAC_BITS +: DATA_W];
    endfunction

    logic w_en;
    logic [CNT_W-1:0] w_ncols;
    logic [CNT_W-1:0] w_nrows;

    // Stage A: word taken from the queue.
    logic  r_a_v;
    t_item r_a_item;
    // Stage B: offsets from origin.
    logic r_b_v, r_b_q, r_b_px, r_b_py;
    logic [DATA_W-1:0] r_b_dx, r_b_dy;
    logic [FIELD_IDX_W-1:0] r_b_row, r_b_col;
    logic [DATA_W-1:0] r_b_sample;
    // Stage C: scaled products.
    logic r_c_v, r_c_q;
    logic [MUL_W-1:0] r_c_mx, r_c_my;
    logic [FIELD_IDX_W-1:0] r_c_row, r_c_col;
    logic [DATA_W-1:0] r_c_sample;
    // Stage D: clamped cell and fractions.
    logic r_d_v, r_d_q;
    logic [CIDX_W-1:0] r_d_c;
    logic [RIDX_W-1:0] r_d_r;
    logic [FRAC_BITS-1:0] r_d_fx, r_d_fy;
    logic [FIELD_IDX_W-1:0] r_d_row, r_d_col;
    logic [DATA_W-1:0] r_d_sample;
    // Stage E: corner samples arrive from the grid store.
    logic r_e_v;
    logic [FRAC_BITS-1:0] r_e_fx, r_e_fy;
    logic [DATA_W-1:0] w_q [4];
    // Stage F: weighted corners.
    logic r_f_v;
    logic [FRAC_BITS-1:0] r_f_fx;
    logic signed [PROD_W-1:0] r_f_p [4];
    // Stage G: column blends.
    logic r_g_v;
    logic [FRAC_BITS-1:0] r_g_fx;
    logic signed [DATA_W-1:0] r_g_r0, r_g_r1;
    // Stage H: weighted column blends.
    logic r_h_v;
    logic signed [PROD_W-1:0] r_h_p0, r_h_p1;
    // Output register.
    logic r_o_v;
    logic signed [DATA_W-1:0] r_o_value;

    logic signed [DATA_W:0] w_dx, w_dy;
    logic [LIM_W-1:0] w_lim_x, w_lim_y;
    logic [POS_W-1:0] w_pos_x;
    logic [POSR_W-1:0] w_pos_y;
    logic [SH_W-1:0] w_sh_x, w_sh_y;
    logic w_ld_ok, w_we, w_re;
    logic [ADDR_W-1:0] w_raddr [4];
    logic [W_W-1:0] w_wy0, w_wy1, w_wx0, w_wx1;

    assign w_en    = !r_o_v || i_out_ready;
    assign o_ready = w_en;
    assign o_valid = r_o_v;
    assign o_value = r_o_value;

    always_comb begin
        if (i_cfg.cols < CNT_W'(2)) begin
            w_ncols = CNT_W'(2);
        end else if (i_cfg.cols > CNT_W'(MAX_COLS)) begin
            w_ncols = CNT_W'(MAX_COLS);
        end else begin
            w_ncols = i_cfg.cols;
        end
        if (i_cfg.rows < CNT_W'(2)) begin
            w_nrows = CNT_W'(2);
        end else if (i_cfg.rows > CNT_W'(MAX_ROWS)) begin
            w_nrows = CNT_W'(MAX_ROWS);
        end else begin
            w_nrows = i_cfg.rows;
        end

        w_dx = {r_a_item.query_x[DATA_W-1], r_a_item.query_x}
             - {i_cfg.x_origin[DATA_W-1], i_cfg.x_origin};
        w_dy = {r_a_item.query_y[DATA_W-1], r_a_item.query_y}
             - {i_cfg.y_origin[DATA_W-1], i_cfg.y_origin};

        w_lim_x = {w_ncols - CNT_W'(1), FRAC_BITS'(0)} - LIM_W'(1);
        w_lim_y = {w_nrows - CNT_W'(1), FRAC_BITS'(0)} - LIM_W'(1);
        w_sh_x  = r_c_mx[MUL_W-1:FRAC_BITS];
        w_sh_y  = r_c_my[MUL_W-1:FRAC_BITS];
        w_pos_x = (w_sh_x > SH_W'(w_lim_x)) ? POS_W'(w_lim_x) : w_sh_x[POS_W-1:0];
        w_pos_y = (w_sh_y > SH_W'(w_lim_y)) ? POSR_W'(w_lim_y) : w_sh_y[POSR_W-1:0];

        w_ld_ok = (32'(r_d_row) < MAX_ROWS) && (32'(r_d_col) < MAX_COLS);
        w_we    = w_en && r_d_v && !r_d_q && w_ld_ok;
        w_re    = w_en && r_d_v && r_d_q;
        w_raddr[0] = grid_addr(r_d_r, r_d_c);
        w_raddr[1] = grid_addr(r_d_r + RIDX_W'(1), r_d_c);
        w_raddr[2] = grid_addr(r_d_r, r_d_c + CIDX_W'(1));
        w_raddr[3] = grid_addr(r_d_r + RIDX_W'(1), r_d_c + CIDX_W'(1));

        w_wy1 = {1'b0, r_e_fy};
        w_wy0 = W_W'(ONE) - w_wy1;
        w_wx1 = {1'b0, r_g_fx};
        w_wx0 = W_W'(ONE) - w_wx1;
    end

    for (genvar k = 0; k < 4; k++) begin : g_store
        bgi_ram #(
            .WIDTH (DATA_W),
            .DEPTH (GRID_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (grid_addr(RIDX_W'(r_d_row), CIDX_W'(r_d_col))),
            .i_wdata (r_d_sample),
            .i_re    (w_re),
            .i_raddr (w_raddr[k]),
            .o_rdata (w_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v && r_d_q;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_o_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_item   <= i_item;

            r_b_q      <= (r_a_item.cmd == CMD_QUERY);
            r_b_px     <= !w_dx[DATA_W] && (w_dx != '0);
            r_b_py     <= !w_dy[DATA_W] && (w_dy != '0);
            r_b_dx     <= w_dx[DATA_W-1:0];
            r_b_dy     <= w_dy[DATA_W-1:0];
            r_b_row    <= r_a_item.row_index;
            r_b_col    <= r_a_item.col_index;
            r_b_sample <= r_a_item.sample_value;

            r_c_q      <= r_b_q;
            r_c_mx     <= r_b_px ? MUL_W'(r_b_dx) * MUL_W'(i_cfg.x_scale) : '0;
            r_c_my     <= r_b_py ? MUL_W'(r_b_dy) * MUL_W'(i_cfg.y_scale) : '0;
            r_c_row    <= r_b_row;
            r_c_col    <= r_b_col;
            r_c_sample <= r_b_sample;

            r_d_q      <= r_c_q;
            r_d_c      <= w_pos_x[POS_W-1:FRAC_BITS];
            r_d_r      <= w_pos_y[POSR_W-1:FRAC_BITS];
            r_d_fx     <= w_pos_x[FRAC_BITS-1:0];
            r_d_fy     <= w_pos_y[FRAC_BITS-1:0];
            r_d_row    <= r_c_row;
            r_d_col    <= r_c_col;
            r_d_sample <= r_c_sample;

            r_e_fx     <= r_d_fx;
            r_e_fy     <= r_d_fy;

            r_f_fx     <= r_e_fx;
            r_f_p[0]   <= PROD_W'($signed(w_q[0]) * $signed({1'b0, w_wy0}));
            r_f_p[1]   <= PROD_W'($signed(w_q[1]) * $signed({1'b0, w_wy1}));
            r_f_p[2]   <= PROD_W'($signed(w_q[2]) * $signed({1'b0, w_wy0}));
            r_f_p[3]   <= PROD_W'($signed(w_q[3]) * $signed({1'b0, w_wy1}));

            r_g_fx     <= r_f_fx;
            r_g_r0     <= round_sum(r_f_p[0], r_f_p[1]);
            r_g_r1     <= round_sum(r_f_p[2], r_f_p[3]);

            r_h_p0     <= PROD_W'(r_g_r0 * $signed({1'b0, w_wx0}));
            r_h_p1     <= PROD_W'(r_g_r1 * $signed({1'b0, w_wx1}));

            r_o_value  <= round_sum(r_h_p0, r_h_p1);
        end
    end
endmodule
